// ===== hw/rtl/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types and constants of the constrained minorant characteristic block:
// controller states, command and status groups, fixed field widths.
// ----------------------------------------------------------------------------
package cmc_pkg;

   localparam int DATA_W      = 32;
   localparam int LEN_W       = 31;
   localparam int REQ_TDATA_W = 352;
   localparam int RSP_TDATA_W = 64;
   localparam int SUB_W       = 3;

   localparam logic [SUB_W-1:0] SETUP_LAST = 3'd3;
   localparam logic [SUB_W-1:0] DRAIN_LAST = 3'd6;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETUP  = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_RUN    = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic first;
      logic step_latch;
      logic point_init;
      logic issue;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic issue_last;
      logic out_free;
   } ctl_status_type;

endpackage

// ===== hw/rtl/constrained_minorant_characteristic_top.sv =====
// ----------------------------------------------------------------------------
// constrained_minorant_characteristic_top
// Segment characteristic for constrained Lipschitz optimization: running
// per-point maximum of minorants, then minimum over points and its location.
// The duration of a function beat is set by the point sweep of the evaluation
// pipeline; the first beat of a segment adds the spacing setup, the closing
// beat the loading of the result. A new beat is taken only after the previous
// one has been processed and drained; one result per segment.
// Reset: synchronous, clears control, counters, spacing and threshold register.
// ----------------------------------------------------------------------------
module constrained_minorant_characteristic_top #(
   parameter int NUM_POINTS = 200,
   parameter int MAX_FUNCS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // seg_start, seg_length, left_break, right_break, left_peak_value,
   // left_peak_pos, right_peak_value, right_peak_pos, mid_value, mid_pos,
   // lip_const, zero pad
   input  logic [cmc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // char_value, char_point
   output logic [cmc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wen,
   input  logic [cmc_pkg::DATA_W-1:0]          csr_wdata
);
   import cmc_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   cmc_ctrl #(
      .MAX_FUNCS (MAX_FUNCS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   cmc_datapath #(
      .NUM_POINTS (NUM_POINTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/cmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmc_ctrl
// Sequencer: takes one beat, runs spacing setup on a segment's first function,
// issues all points to the datapath, drains, on tlast hands off the result.
// ----------------------------------------------------------------------------
module cmc_ctrl #(
   parameter int MAX_FUNCS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tlast,
   input  cmc_pkg::ctl_status_type status,
   output cmc_pkg::ctl_cmd_type    cmd
);
   import cmc_pkg::*;

   localparam int CNT_W = $clog2(MAX_FUNCS + 1);

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;
   logic [SUB_W-1:0] sub_ff, sub_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      first_in = first_ff;
      last_in  = last_ff;
      sub_in   = sub_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               cmd.first = (count_ff == '0);
               first_in  = (count_ff == '0);
               last_in   = req_tlast;
               sub_in    = '0;
               if (count_ff < CNT_W'(MAX_FUNCS)) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = (count_ff == '0) ? ST_SETUP : ST_PREP;
            end
         end
         ST_SETUP: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == SETUP_LAST) begin
               cmd.step_latch = 1'b1;
               state_in       = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.point_init = 1'b1;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            cmd.first = first_ff;
            if (status.issue_last) begin
               sub_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == DRAIN_LAST) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         first_ff <= 1'b0;
         last_ff  <= 1'b0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         sub_ff   <= sub_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.step_latch |-> first_ff)
      else $error("spacing latched on a function that is not the first");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (status.out_free && last_ff))
      else $error("result loaded while output busy or segment not closed");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken before the first was processed");

endmodule

// ===== hw/rtl/cmc_datapath.sv =====
// ----------------------------------------------------------------------------
// cmc_datapath
// Item registers, point spacing by reciprocal multiply, point generator,
// five-stage minorant evaluation, per-point maximum memory, minimum tracker
// and result register.
// ----------------------------------------------------------------------------
module cmc_datapath #(
   parameter int NUM_POINTS = 200
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmc_pkg::ctl_cmd_type                cmd,
   output cmc_pkg::ctl_status_type             status,
   input  logic [cmc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                csr_wen,
   input  logic [cmc_pkg::DATA_W-1:0]          csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cmc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import cmc_pkg::*;

   localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int DIV = NUM_POINTS + 1;
   localparam int DIV_W = $clog2(DIV + 1);
   localparam int DIV_SHIFT = LEN_W + $clog2(DIV);
   localparam logic [31:0] DIV_MULT = 32'((64'd1 << DIV_SHIFT) / DIV);
   localparam int QD_W = LEN_W + DIV_W;
   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

   typedef struct packed {
      logic                    first;
      logic                    neg;
      logic [IDX_W-1:0]        idx;
      logic signed [31:0]      point;
      logic signed [31:0]      val;
   } tag_type;

   function automatic logic signed [31:0] sat_32(input logic signed [49:0] v);
      if (v > SAT_HI) begin
         return 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         return 32'sh80000000;
      end else begin
         return signed'(v[31:0]);
      end
   endfunction

   // configuration and item registers
   logic signed [31:0] gmin_ff;
   logic signed [31:0] start_hold_ff;
   logic [LEN_W-1:0]   len_ff;
   logic signed [31:0] lb_ff, rb_ff, lv_ff, lp_ff, rv_ff, rp_ff, mv_ff, mp_ff;
   logic [LEN_W-1:0]   lip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gmin_ff <= '0;
      end else if (csr_wen) begin
         gmin_ff <= signed'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hold_ff <= '0;
      end else if (cmd.load && cmd.first) begin
         start_hold_ff <= signed'(req_tdata[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= req_tdata[62:32];
         lb_ff  <= signed'(req_tdata[94:63]);
         rb_ff  <= signed'(req_tdata[126:95]);
         lv_ff  <= signed'(req_tdata[158:127]);
         lp_ff  <= signed'(req_tdata[190:159]);
         rv_ff  <= signed'(req_tdata[222:191]);
         rp_ff  <= signed'(req_tdata[254:223]);
         mv_ff  <= signed'(req_tdata[286:255]);
         mp_ff  <= signed'(req_tdata[318:287]);
         lip_ff <= req_tdata[349:319];
      end
   end

   // spacing: length / (points + 1), reciprocal estimate plus one correction
   logic [62:0]      prod_ff;
   logic [LEN_W-1:0] q0_ff;
   logic [QD_W-1:0]  qd_ff;
   logic [QD_W-1:0]  rem;
   logic [LEN_W-1:0] step_in;
   logic [LEN_W-1:0] step_hold_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 63'(len_ff) * 63'(DIV_MULT);
      q0_ff   <= LEN_W'(prod_ff >> DIV_SHIFT);
      qd_ff   <= QD_W'(q0_ff) * QD_W'(DIV);
   end

   always_comb begin
      rem     = QD_W'(len_ff) - qd_ff;
      step_in = (rem >= QD_W'(DIV)) ? q0_ff + 1'b1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_hold_ff <= '0;
      end else if (cmd.step_latch) begin
         step_hold_ff <= step_in;
      end
   end

   // point generator
   logic signed [33:0] acc_ff;
   logic [IDX_W-1:0]   idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.point_init) begin
         acc_ff <= {{2{start_hold_ff[31]}}, start_hold_ff} + {3'd0, step_hold_ff};
      end else if (cmd.issue) begin
         acc_ff <= acc_ff + {3'd0, step_hold_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.point_init) begin
         idx_ff <= '0;
      end else if (cmd.issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // stage 0: piece choice and distance to vertex
   logic signed [31:0] p0_point;
   logic signed [31:0] p0_pos;
   logic signed [32:0] p0_d;
   logic [32:0]        p0_ad;
   tag_type            p0_tag;

   always_comb begin
      p0_point = sat_32({{16{acc_ff[33]}}, acc_ff});
      p0_tag.first = cmd.first;
      p0_tag.idx   = idx_ff;
      p0_tag.point = p0_point;
      priority if (p0_point < lb_ff) begin
         p0_tag.val = lv_ff;
         p0_pos     = lp_ff;
         p0_tag.neg = 1'b1;
      end else if (p0_point > rb_ff) begin
         p0_tag.val = rv_ff;
         p0_pos     = rp_ff;
         p0_tag.neg = 1'b1;
      end else begin
         p0_tag.val = mv_ff;
         p0_pos     = mp_ff;
         p0_tag.neg = 1'b0;
      end
      p0_d  = {p0_point[31], p0_point} - {p0_pos[31], p0_pos};
      p0_ad = p0_d[32] ? 33'(-p0_d) : 33'(p0_d);
   end

   // stages 1 to 5
   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   tag_type     s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [31:0] s1_ad_ff;
   logic [39:0] s2_sq_ff;
   logic [38:0] s3_hi_ff;
   logic [62:0] s3_lo_ff;

   logic               s4_first_ff;
   logic [IDX_W-1:0]   s4_idx_ff;
   logic signed [31:0] s4_point_ff;
   logic signed [31:0] s4_v_ff;
   logic signed [31:0] rd_ff;

   logic [IDX_W-1:0]   s5_idx_ff;
   logic signed [31:0] s5_point_ff;
   logic signed [31:0] s5_final_ff;

   logic signed [31:0] point_mem [NUM_POINTS];

   logic [46:0]        s3_term;
   logic signed [49:0] s3_term_s, s3_base, s3_gsub, s3_wide;
   logic signed [31:0] s4_final;

   always_comb begin
      s3_term   = 47'({s3_hi_ff, 7'd0}) + 47'(s3_lo_ff >> 25);
      s3_term_s = signed'({3'd0, s3_term});
      s3_base   = {{18{s3_tag_ff.val[31]}}, s3_tag_ff.val};
      s3_gsub   = s3_tag_ff.first ? {{18{gmin_ff[31]}}, gmin_ff} : '0;
      s3_wide   = s3_tag_ff.neg ? s3_base - s3_term_s - s3_gsub
                                : s3_base + s3_term_s - s3_gsub;
      s4_final  = (s4_first_ff || (s4_v_ff > rd_ff)) ? s4_v_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff   <= p0_tag;
      s1_ad_ff    <= p0_ad[31:0];
      s2_tag_ff   <= s1_tag_ff;
      s2_sq_ff    <= 40'((64'(s1_ad_ff) * 64'(s1_ad_ff)) >> 24);
      s3_tag_ff   <= s2_tag_ff;
      s3_hi_ff    <= 39'(s2_sq_ff[39:32]) * 39'(lip_ff);
      s3_lo_ff    <= 63'(s2_sq_ff[31:0]) * 63'(lip_ff);
      s4_first_ff <= s3_tag_ff.first;
      s4_idx_ff   <= s3_tag_ff.idx;
      s4_point_ff <= s3_tag_ff.point;
      s4_v_ff     <= sat_32(s3_wide);
      s5_idx_ff   <= s4_idx_ff;
      s5_point_ff <= s4_point_ff;
      s5_final_ff <= s4_final;
   end

   always_ff @(posedge clock) begin
      rd_ff <= point_mem[s3_tag_ff.idx];
      if (s4_valid_ff) begin
         point_mem[s4_idx_ff] <= s4_final;
      end
   end

   // minimum over points, first point wins a tie
   logic signed [31:0] min_val_ff;
   logic signed [31:0] min_point_ff;

   always_ff @(posedge clock) begin
      if (s5_valid_ff && ((s5_idx_ff == '0) || (s5_final_ff < min_val_ff))) begin
         min_val_ff   <= s5_final_ff;
         min_point_ff <= s5_point_ff;
      end
   end

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {min_point_ff, min_val_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.issue_last = (idx_ff == IDX_W'(NUM_POINTS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assert property (@(posedge clock) disable iff (reset)
      cmd.point_init |=> (idx_ff == '0))
      else $error("point index not cleared at start of sweep");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && (idx_ff == '0)) |-> $past(cmd.point_init))
      else $error("sweep started without point generator init");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!s1_valid_ff && !s3_valid_ff && !s4_valid_ff && !s5_valid_ff))
      else $error("result taken while evaluation pipeline still busy");

endmodule

// ===== dv/tb_constrained_minorant_characteristic_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_constrained_minorant_characteristic_top
// Self-checking bench for the constrained minorant characteristic block.
// Minorant beats are streamed in segment by segment. A predictor running
// alongside the bus folds every accepted beat into its own per-point maxima
// and queues the characteristic that a closing beat must produce. Each result
// beat is compared field by field with the oldest queued characteristic.
// Directed segments cover piece selection, ties, saturation, ignored segment
// bounds and function-count overflow. Random phases under several threshold
// settings follow, with random idling on both sides, one long receiver hold
// and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_constrained_minorant_characteristic_top;
   import cmc_pkg::*;

   localparam int NUM_POINTS       = 200;
   localparam int MAX_FUNCS        = 16;
   localparam int ONE              = 1 << 24;
   localparam int SETTLE_CYCLES    = NUM_POINTS + 9 + 4 + 1 + 16;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int CYCLE_LIMIT      = 2000000;
   localparam longint WORD_MAX     = 2147483647;
   localparam longint WORD_MIN     = -WORD_MAX - 1;

   // seg_start, seg_length, left_break, right_break, left_peak_value,
   // left_peak_pos, right_peak_value, right_peak_pos, mid_value, mid_pos,
   // lip_const, zero pad (lowest bit first)
   typedef struct packed {
      bit [1:0]  pad;
      bit [30:0] lip_const;
      int        mid_pos;
      int        mid_value;
      int        right_peak_pos;
      int        right_peak_value;
      int        left_peak_pos;
      int        left_peak_value;
      int        right_break;
      int        left_break;
      bit [30:0] seg_length;
      int        seg_start;
   } minorant_beat_type;

   // char_value, char_point (lowest bit first)
   typedef struct packed {
      int char_point;
      int char_value;
   } characteristic_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_wen;
   logic [DATA_W-1:0]      csr_wdata;

   characteristic_type expected_chars[$];
   int              point_max[NUM_POINTS];
   int              funcs_in_segment = 0;
   longint          start_hold = 0;
   longint          step_hold = 0;
   longint          min_estimate = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              beat_gap_pct = 0;
   int              stall_pct = 0;
   bit              hold_request = 1'b0;

   constrained_minorant_characteristic_top #(
      .NUM_POINTS(NUM_POINTS),
      .MAX_FUNCS (MAX_FUNCS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint sat_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // floor(floor(d*d / 2^24) * L / 2^25), i.e. L/2 * d^2 in Q8.24
   function automatic longint curvature_term(longint d, bit [30:0] lip);
      bit [63:0] mag, sq, hi, lo, lip64;
      mag   = (d < 0) ? -d : d;
      sq    = (mag * mag) >> 24;
      hi    = sq >> 32;
      lo    = sq & 64'hFFFF_FFFF;
      lip64 = 64'(lip);
      return longint'(((hi * lip64) << 7) + ((lo * lip64) >> 25));
   endfunction

   function automatic longint grid_point(int idx);
      return sat_word(start_hold + step_hold * longint'(idx + 1));
   endfunction

   function automatic void fold_minorant(minorant_beat_type b, logic closes);
      longint             p, v;
      bit                 opening;
      int                 best, lowest;
      characteristic_type c;
      opening = (funcs_in_segment == 0);
      if (opening) begin
         start_hold = longint'(b.seg_start);
         step_hold  = longint'(b.seg_length) / (NUM_POINTS + 1);
      end
      for (int i = 0; i < NUM_POINTS; i++) begin
         p = grid_point(i);
         if (p < longint'(b.left_break)) begin
            v = longint'(b.left_peak_value)
                - curvature_term(p - longint'(b.left_peak_pos), b.lip_const);
         end else if (p > longint'(b.right_break)) begin
            v = longint'(b.right_peak_value)
                - curvature_term(p - longint'(b.right_peak_pos), b.lip_const);
         end else begin
            v = longint'(b.mid_value)
                + curvature_term(p - longint'(b.mid_pos), b.lip_const);
         end
         if (opening) v -= min_estimate;
         v = sat_word(v);
         if (opening || v > longint'(point_max[i])) point_max[i] = int'(v);
      end
      if (funcs_in_segment < MAX_FUNCS) funcs_in_segment++;
      if (closes) begin
         best   = 0;
         lowest = point_max[0];
         for (int i = 1; i < NUM_POINTS; i++) begin
            if (point_max[i] < lowest) begin
               lowest = point_max[i];
               best   = i;
            end
         end
         c.char_value = lowest;
         c.char_point = int'(grid_point(best));
         expected_chars.push_back(c);
         funcs_in_segment = 0;
      end
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      characteristic_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) fold_minorant(minorant_beat_type'(req_tdata), req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = characteristic_type'(rsp_tdata);
            if (expected_chars.size() == 0) begin
               $error("unexpected result beat: char_value %0d, char_point %0d",
                      got.char_value, got.char_point);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (got.char_value !== want.char_value) begin
                  $error("char_value: expected %0d, got %0d", want.char_value, got.char_value);
                  mismatch_count++;
               end
               if (got.char_point !== want.char_point) begin
                  $error("char_point: expected %0d, got %0d", want.char_point, got.char_point);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_beat(input minorant_beat_type beat, input bit closes);
      @(negedge clock);
      if (beat_gap_pct != 0 && $urandom_range(1, 100) <= beat_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tdata  <= beat;
      req_tlast  <= closes;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_min_estimate(input int value);
      wait_drained();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      min_estimate = value;
   endtask

   // points at 0.5 .. 100.0, breaks at 25 and 75, vertex of the middle at 50
   function automatic minorant_beat_type plain_minorant();
      minorant_beat_type b;
      b                  = '0;
      b.seg_length       = 31'(201 * (ONE / 2));
      b.left_break       = 25 * ONE;
      b.right_break      = 75 * ONE;
      b.left_peak_value  = 10 * ONE;
      b.left_peak_pos    = 12 * ONE;
      b.right_peak_value = 12 * ONE;
      b.right_peak_pos   = 90 * ONE;
      b.mid_value        = -ONE;
      b.mid_pos          = 50 * ONE;
      b.lip_const        = 31'(ONE / 64);
      return b;
   endfunction

   function automatic minorant_beat_type random_minorant(bit wild);
      minorant_beat_type b;
      int                span;
      b = '0;
      if (wild) begin
         b.seg_start        = $urandom;
         b.seg_length       = 31'($urandom);
         b.left_break       = $urandom;
         b.right_break      = $urandom;
         b.left_peak_value  = $urandom;
         b.left_peak_pos    = $urandom;
         b.right_peak_value = $urandom;
         b.right_peak_pos   = $urandom;
         b.mid_value        = $urandom;
         b.mid_pos          = $urandom;
         b.lip_const        = 31'($urandom);
      end else begin
         b.seg_start        = int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
         b.seg_length       = 31'($urandom_range(0, 32'h1000_0000));
         span               = int'(b.seg_length);
         b.left_break       = b.seg_start + int'($urandom_range(0, span)) - span / 4;
         b.right_break      = b.left_break + int'($urandom_range(0, span)) - span / 8;
         b.left_peak_pos    = b.seg_start + int'($urandom_range(0, span)) - span / 4;
         b.right_peak_pos   = b.seg_start + int'($urandom_range(0, span)) - span / 4;
         b.mid_pos          = b.seg_start + int'($urandom_range(0, span)) - span / 4;
         b.left_peak_value  = int'($urandom) >>> $urandom_range(2, 8);
         b.right_peak_value = int'($urandom) >>> $urandom_range(2, 8);
         b.mid_value        = int'($urandom) >>> $urandom_range(2, 8);
         b.lip_const        = 31'($urandom_range(0, 32'h0800_0000) >> $urandom_range(0, 6));
      end
      return b;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_single_function();
      send_beat(plain_minorant(), 1'b1);
   endtask

   task automatic test_piece_boundaries();
      minorant_beat_type b;
      // both breaks exactly on a point: the middle piece applies there
      b             = plain_minorant();
      b.left_break  = 40 * ONE;
      b.right_break = 40 * ONE;
      b.lip_const   = 31'(ONE / 16);
      send_beat(b, 1'b1);
      // crossed breaks
      b             = plain_minorant();
      b.left_break  = 70 * ONE;
      b.right_break = 30 * ONE;
      send_beat(b, 1'b1);
      // flat minorant, every point ties
      b                  = plain_minorant();
      b.lip_const        = '0;
      b.left_peak_value  = 3 * ONE;
      b.right_peak_value = 3 * ONE;
      b.mid_value        = 3 * ONE;
      send_beat(b, 1'b1);
   endtask

   task automatic test_field_extremes();
      minorant_beat_type b;
      // points saturate high, curvature far beyond range
      b                  = '0;
      b.seg_start        = int'(WORD_MAX);
      b.seg_length       = '1;
      b.left_break       = int'(WORD_MIN);
      b.right_break      = int'(WORD_MAX);
      b.left_peak_value  = int'(WORD_MIN);
      b.left_peak_pos    = int'(WORD_MIN);
      b.right_peak_value = int'(WORD_MAX);
      b.right_peak_pos   = int'(WORD_MIN);
      b.mid_value        = int'(WORD_MAX);
      b.mid_pos          = int'(WORD_MIN);
      b.lip_const        = '1;
      send_beat(b, 1'b1);
      // zero length at the bottom of the range, two functions
      b.seg_start       = int'(WORD_MIN);
      b.seg_length      = '0;
      b.left_break      = int'(WORD_MAX);
      b.left_peak_value = int'(WORD_MIN);
      b.left_peak_pos   = int'(WORD_MAX);
      send_beat(b, 1'b0);
      b.left_break  = int'(WORD_MIN);
      b.right_break = int'(WORD_MAX);
      b.mid_value   = int'(WORD_MIN);
      b.mid_pos     = int'(WORD_MAX);
      send_beat(b, 1'b1);
   endtask

   task automatic test_bounds_ignored();
      minorant_beat_type b;
      b = plain_minorant();
      send_beat(b, 1'b0);
      b.seg_start  = -40 * ONE;
      b.seg_length = 31'(201 * (ONE / 4));
      b.mid_value  = 2 * ONE;
      b.lip_const  = 31'(ONE / 8);
      send_beat(b, 1'b1);
   endtask

   task automatic test_function_overflow();
      for (int k = 0; k <= MAX_FUNCS; k++) send_beat(random_minorant(1'b0), k == MAX_FUNCS);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int k = 0; k < 16; k++) send_beat(random_minorant(1'b0), 1'b1);
      wait_drained();
   endtask

   task automatic run_random_phase(input int beats, input bit idling);
      int sent, nfuncs, pick;
      sent = 0;
      while (sent < beats) begin
         pick = $urandom_range(1, 100);
         if (pick <= 70) nfuncs = $urandom_range(1, 3);
         else if (pick <= 95) nfuncs = $urandom_range(4, 8);
         else nfuncs = $urandom_range(15, 20);
         if (idling) begin
            case ($urandom_range(0, 3))
               0, 1: beat_gap_pct = 0;
               2: beat_gap_pct = 15;
               default: beat_gap_pct = 40;
            endcase
            case ($urandom_range(0, 3))
               0, 1: stall_pct = 0;
               2: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         for (int k = 0; k < nfuncs; k++) begin
            send_beat(random_minorant($urandom_range(1, 100) <= 15), k == nfuncs - 1);
         end
         sent += nfuncs;
      end
   endtask

   task automatic test_min_estimate_settings();
      int settings[6];
      settings = '{int'(WORD_MAX), int'(WORD_MIN), -ONE, int'($urandom), 0, int'($urandom)};
      foreach (settings[s]) begin
         set_min_estimate(settings[s]);
         run_random_phase(220, 1'b1);
      end
   endtask

   task automatic test_full_rate();
      set_min_estimate(int'($urandom) >>> 4);
      beat_gap_pct = 0;
      stall_pct    = 0;
      run_random_phase(100, 1'b0);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      beat_gap_pct = 20;
      stall_pct    = 20;
      test_single_function();
      test_piece_boundaries();
      test_field_extremes();
      test_bounds_ignored();
      test_function_overflow();
      test_backpressure();
      test_min_estimate_settings();
      test_full_rate();
      wait_drained();

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_ctrl.sv
hw/rtl/cmc_datapath.sv
hw/rtl/constrained_minorant_characteristic_top.sv
dv/tb_constrained_minorant_characteristic_top.sv
